>>> rtl/aifp_pkg.sv
// ----------------------------------------------------------------------------
// aifp_pkg
// Shared types and constants for the ASCII integer field parser.
// ----------------------------------------------------------------------------
package aifp_pkg;

  // Default width of the "long" size.
  localparam int LONG_BITS_DEF = 64;

  // Width of the parsed value and of the accumulator.
  localparam int VAL_W = 64;

  // Configuration register indexes.
  localparam logic CFG_CONV_MODE   = 1'b0;
  localparam logic CFG_SIZE_SELECT = 1'b1;

  // Conversion modes.
  localparam logic [2:0] MODE_SDEC = 3'd0;
  localparam logic [2:0] MODE_AUTO = 3'd1;
  localparam logic [2:0] MODE_OCT  = 3'd2;
  localparam logic [2:0] MODE_UDEC = 3'd3;
  localparam logic [2:0] MODE_HEX  = 3'd4;

  // Size selections.
  localparam logic [2:0] SIZE_CHAR  = 3'd0;
  localparam logic [2:0] SIZE_SHORT = 3'd1;
  localparam logic [2:0] SIZE_INT   = 3'd2;
  localparam logic [2:0] SIZE_LONG  = 3'd3;
  localparam logic [2:0] SIZE_LLONG = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [2:0] CONV_MODE_RST   = MODE_AUTO;
  localparam logic [2:0] SIZE_SELECT_RST = SIZE_INT;

  // Parse phase, one-hot.
  typedef enum logic [3:0] {
    PH_SKIP   = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_ZERO   = 4'b0100,
    PH_DIGITS = 4'b1000
  } phase_t;

  // Radix of the field being parsed.
  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_OCT = 2'd1,
    RX_HEX = 2'd2
  } radix_t;

  // Decoded configuration handed to the parse logic.
  typedef struct packed {
    logic [2:0]       mode;
    logic [VAL_W-1:0] mask;
    logic [VAL_W-1:0] limit;
  } cfg_t;

  // One result beat from the parse logic.
  typedef struct packed {
    logic             emit;
    logic [VAL_W-1:0] value;
    logic             status;
  } result_t;

endpackage

>>> rtl/aifp_cfg.sv
// ----------------------------------------------------------------------------
// aifp_cfg
// Configuration registers and decode of the size mask and the value limit.
// ----------------------------------------------------------------------------
module aifp_cfg #(
  parameter int LONG_BITS = aifp_pkg::LONG_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [2:0]     cfg_wdata,
  output aifp_pkg::cfg_t cfg
);
  import aifp_pkg::*;

  // Mask of the "long" size, all ones when it is 64 bits wide.
  localparam logic [VAL_W-1:0] LONG_MASK = ~(VAL_W)'(0) >> (VAL_W - LONG_BITS);

  logic [2:0]       conv_mode_r;
  logic [2:0]       size_select_r;
  logic [VAL_W-1:0] mask;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_mode_r   <= CONV_MODE_RST;
      size_select_r <= SIZE_SELECT_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_CONV_MODE) begin
        conv_mode_r <= cfg_wdata;
      end else begin
        size_select_r <= cfg_wdata;
      end
    end
  end

  // Size mask; unused codes fall back to int.
  always_comb begin
    case (size_select_r)
      SIZE_CHAR:  mask = (VAL_W)'(64'hFF);
      SIZE_SHORT: mask = (VAL_W)'(64'hFFFF);
      SIZE_LONG:  mask = LONG_MASK;
      SIZE_LLONG: mask = ~(VAL_W)'(0);
      default:    mask = (VAL_W)'(64'hFFFF_FFFF);
    endcase
  end

  // Signed modes stop at the largest positive value.
  assign cfg.mode  = conv_mode_r;
  assign cfg.mask  = mask;
  assign cfg.limit = (conv_mode_r == MODE_SDEC || conv_mode_r == MODE_AUTO) ?
                     (mask >> 1) : mask;

endmodule

>>> rtl/aifp_core.sv
// ----------------------------------------------------------------------------
// aifp_core
// Field state and the per-character parse step: prefix, sign and digit
// handling, multiply-accumulate in the chosen base and the limit check.
// ----------------------------------------------------------------------------
module aifp_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        char_in,
  input  aifp_pkg::cfg_t    cfg,
  output aifp_pkg::result_t result
);
  import aifp_pkg::*;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LF_   = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam int         PROD_W   = VAL_W + 5;

  phase_t           phase_r, phase_nxt;
  logic [VAL_W-1:0] accum_r, accum_nxt;
  logic             negative_r, negative_nxt;
  radix_t           radix_r, radix_nxt;
  logic             overflowed_r, overflowed_nxt;
  logic             digit_seen_r, digit_seen_nxt;

  phase_t            phase_fin_nxt;
  radix_t            radix_fin_nxt;
  logic              digit_seen_fin_nxt;

  logic              is_sp;
  logic              is_nul;
  logic              is_dig;
  logic [3:0]        dval;
  logic              signed_mode;
  logic              emit;
  logic              err;
  logic              do_digit;
  radix_t            rx;
  logic              ds;
  logic [4:0]        base;
  logic [PROD_W-1:0] prod;
  logic [VAL_W-1:0]  signed_val;

  // Character classes.
  assign is_sp  = (char_in == CH_SPACE) || (char_in == CH_TAB) || (char_in == CH_LF);
  assign is_nul = (char_in == CH_NUL);
  assign signed_mode = (cfg.mode == MODE_SDEC) || (cfg.mode == MODE_AUTO);

  // Hex-capable digit decode.
  always_comb begin
    is_dig = 1'b1;
    dval   = 4'd0;
    if (char_in inside {[CH_ZERO:CH_NINE]}) begin
      dval = 4'(char_in - CH_ZERO);
    end else if (char_in inside {[CH_UA:CH_UF]}) begin
      dval = 4'(char_in - CH_UA + 8'd10);
    end else if (char_in inside {[CH_LA:CH_LF_]}) begin
      dval = 4'(char_in - CH_LA + 8'd10);
    end else begin
      is_dig = 1'b0;
    end
  end

  // Phase handling before the digit step; rx and ds are the radix and
  // digit-seen flag that the digit step sees.
  always_comb begin
    phase_nxt      = phase_r;
    negative_nxt   = negative_r;
    radix_nxt      = radix_r;
    digit_seen_nxt = digit_seen_r;
    emit           = 1'b0;
    err            = 1'b0;
    do_digit       = 1'b0;
    rx             = radix_r;
    ds             = digit_seen_r;
    if (cfg.mode > MODE_HEX) begin
      emit = 1'b1;
      err  = 1'b1;
    end else begin
      case (phase_r)
        PH_SIGN: begin
          if (char_in == CH_ZERO) begin
            phase_nxt      = PH_ZERO;
            digit_seen_nxt = 1'b1;
          end else begin
            do_digit = 1'b1;
          end
        end
        PH_ZERO: begin
          if (char_in == CH_LX || char_in == CH_UX) begin
            if (cfg.mode != MODE_AUTO && cfg.mode != MODE_HEX) begin
              emit = 1'b1;
              err  = 1'b1;
            end else begin
              radix_nxt      = RX_HEX;
              digit_seen_nxt = 1'b0;
              phase_nxt      = PH_DIGITS;
            end
          end else if ((char_in == CH_LB || char_in == CH_UB) && !signed_mode) begin
            emit = 1'b1;
            err  = 1'b1;
          end else if (signed_mode && (char_in inside {[CH_ZERO:CH_SEVEN]})) begin
            // Octal prefix: only the auto-base mode takes it.
            if (cfg.mode == MODE_SDEC) begin
              emit = 1'b1;
              err  = 1'b1;
            end else begin
              rx       = RX_OCT;
              do_digit = 1'b1;
            end
          end else begin
            do_digit = 1'b1;
          end
        end
        PH_DIGITS: begin
          do_digit = 1'b1;
        end
        default: begin
          // Skip leading space; the first other character picks the radix.
          if (is_sp) begin
            phase_nxt = PH_SKIP;
          end else if (is_nul) begin
            emit = 1'b1;
          end else begin
            case (cfg.mode)
              MODE_OCT: rx = RX_OCT;
              MODE_HEX: rx = RX_HEX;
              default:  rx = RX_DEC;
            endcase
            radix_nxt = rx;
            ds        = 1'b0;
            if (signed_mode && (char_in == CH_MINUS || char_in == CH_PLUS)) begin
              negative_nxt = (char_in == CH_MINUS);
              phase_nxt    = PH_SIGN;
            end else if (char_in == CH_ZERO) begin
              phase_nxt      = PH_ZERO;
              digit_seen_nxt = 1'b1;
            end else begin
              do_digit = 1'b1;
            end
          end
        end
      endcase
    end
  end

  // Base of the digit step and the exact product accum * base + digit.
  always_comb begin
    case (rx)
      RX_HEX: begin
        base = 5'd16;
        prod = ({5'd0, accum_r} << 4) + PROD_W'(dval);
      end
      RX_OCT: begin
        base = 5'd8;
        prod = ({5'd0, accum_r} << 3) + PROD_W'(dval);
      end
      default: begin
        base = 5'd10;
        prod = ({5'd0, accum_r} << 3) + ({5'd0, accum_r} << 1) + PROD_W'(dval);
      end
    endcase
  end

  // Two's complement value of the finished field.
  assign signed_val = negative_r ? (VAL_W)'(0) - accum_r : accum_r;

  // State update; any result returns the field state to its start.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SKIP;
      accum_r      <= '0;
      negative_r   <= 1'b0;
      radix_r      <= RX_DEC;
      overflowed_r <= 1'b0;
      digit_seen_r <= 1'b0;
    end else if (step) begin
      if (result.emit) begin
        phase_r      <= PH_SKIP;
        accum_r      <= '0;
        negative_r   <= 1'b0;
        radix_r      <= RX_DEC;
        overflowed_r <= 1'b0;
        digit_seen_r <= 1'b0;
      end else begin
        phase_r      <= phase_fin_nxt;
        accum_r      <= accum_nxt;
        negative_r   <= negative_nxt;
        radix_r      <= radix_fin_nxt;
        overflowed_r <= overflowed_nxt;
        digit_seen_r <= digit_seen_fin_nxt;
      end
    end
  end

  // Digit step: end of field, bad character, digit out of range, or
  // accumulate with the limit check.
  always_comb begin
    result.emit    = emit;
    result.status  = err;
    accum_nxt      = accum_r;
    overflowed_nxt = overflowed_r;
    if (do_digit) begin
      if (is_nul || (ds && is_sp)) begin
        result.emit   = 1'b1;
        result.status = 1'b0;
      end else if (!is_dig || (5'(dval) >= base)) begin
        result.emit   = 1'b1;
        result.status = 1'b1;
      end else begin
        accum_nxt = prod[VAL_W-1:0];
        if (prod > {5'd0, cfg.limit}) begin
          overflowed_nxt = 1'b1;
        end
      end
    end
    result.value = (result.status || overflowed_r) ? '0 : (signed_val & cfg.mask);
  end

  // The digit step also commits radix, phase and digit-seen.
  always_comb begin
    if (do_digit && !result.emit) begin
      // Overrides of the phase handling for an accepted digit.
      phase_fin_nxt      = PH_DIGITS;
      radix_fin_nxt      = rx;
      digit_seen_fin_nxt = 1'b1;
    end else begin
      phase_fin_nxt      = phase_nxt;
      radix_fin_nxt      = radix_nxt;
      digit_seen_fin_nxt = digit_seen_nxt;
    end
  end

endmodule

>>> rtl/ascii_integer_field_parser_core.sv
// ----------------------------------------------------------------------------
// ascii_integer_field_parser_core
// Parses scanf-style integer fields from a stream of ASCII characters.
// ----------------------------------------------------------------------------
// The block takes one character per cycle while in_stall is low and returns
// one result beat when a field ends (NUL, or whitespace after a digit) or
// fails on a malformed character. A character passes through an input
// register and, once the result slot is free, through the parse step into
// the result register, which holds the result until it is taken with
// out_stall low. The parse step, a shift and add multiply by the base with a
// 69-bit limit compare, sets the clock cycle. A stalled result holds the
// character in the input register, and in_stall holds back the rest.
module ascii_integer_field_parser_core #(
  parameter int LONG_BITS = aifp_pkg::LONG_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_value,
  output logic        out_status,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_wdata
);
  import aifp_pkg::*;

  logic             in_valid_r;
  logic [7:0]       in_char_r;
  logic             out_valid_r;
  logic [VAL_W-1:0] out_value_r;
  logic             out_status_r;
  logic             out_free;
  logic             step;
  cfg_t             cfg;
  result_t          result;

  aifp_cfg #(
    .LONG_BITS (LONG_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  aifp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .char_in (in_char_r),
    .cfg     (cfg),
    .result  (result)
  );

  // The parse step runs when a character waits and the result slot is free.
  assign out_free = !out_valid_r || !out_stall;
  assign step     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !step;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_char_r <= in_char_in;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && result.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && result.emit) begin
      out_value_r  <= result.value;
      out_status_r <= result.status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

>>> test/aifp_field_checker.sv
// ----------------------------------------------------------------------------
// aifp_field_checker
// Watches the parser's channels, predicts every field result and compares.
// ----------------------------------------------------------------------------
// The checker follows each configuration write and each accepted character
// beat. It keeps its own copy of the parse state, and queues the result that a
// character completes. Each accepted result beat is compared field by field
// with the oldest queued result. Mismatches are printed and counted.
module aifp_field_checker #(
  parameter int LONG_BITS = aifp_pkg::LONG_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_char_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] out_value,
  input  logic        out_status,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          checked,
  output int          malformed
);
  timeunit 1ns;
  timeprecision 1ps;
  import aifp_pkg::*;

  // Mask of the "long" size, clamped to 32..64 bits.
  localparam logic [63:0] LONG_MASK = (LONG_BITS >= 64) ? {64{1'b1}} :
                                      (LONG_BITS <= 32) ? 64'hFFFF_FFFF :
                                      (64'd1 << LONG_BITS) - 64'd1;

  typedef struct packed {
    logic [63:0] value;
    logic        status;
  } field_result_t;

  // Predicted results that the block still owes.
  field_result_t expected_fields[$];

  // Shadow copy of the configuration registers.
  logic [2:0] cur_mode;
  logic [2:0] cur_size;

  // Shadow copy of the field being parsed.
  phase_t      fld_phase;
  logic [63:0] fld_accum;
  logic        fld_neg;
  radix_t      fld_radix;
  logic        fld_ovf;
  logic        fld_digit;

  int errs = 0;
  int n_checked = 0;
  int n_malformed = 0;

  assign fail_count = errs;
  assign checked    = n_checked;
  assign malformed  = n_malformed;

  function automatic void clear_field();
    fld_phase = PH_SKIP;
    fld_accum = '0;
    fld_neg   = 1'b0;
    fld_radix = RX_DEC;
    fld_ovf   = 1'b0;
    fld_digit = 1'b0;
  endfunction

  // Advances the field state by one character. Returns 1 when the character
  // completes or fails the field, with the result in v and st.
  function automatic bit parse_step(input logic [7:0] c, output logic [63:0] v,
                                    output logic st);
    logic        fin;
    logic        bad;
    logic        to_digits;
    logic        blank;
    logic [63:0] mask;
    logic [63:0] lim;
    logic [63:0] dig;
    logic [63:0] base;
    fin       = 1'b0;
    bad       = 1'b0;
    to_digits = 1'b0;
    v         = '0;
    st        = 1'b0;
    blank     = (c == " ") || (c == "\t") || (c == "\n");

    case (cur_size)
      SIZE_CHAR: mask = 64'hFF;
      SIZE_SHORT: mask = 64'hFFFF;
      SIZE_LONG: mask = LONG_MASK;
      SIZE_LLONG: mask = {64{1'b1}};
      default: mask = 64'hFFFF_FFFF;
    endcase
    // Signed modes stop at the largest positive value.
    lim = (cur_mode <= MODE_AUTO) ? (mask >> 1) : mask;

    if (cur_mode > MODE_HEX) begin
      fin = 1'b1;
      bad = 1'b1;
    end else begin
      case (fld_phase)
        PH_SIGN: begin
          if (c == "0") begin
            fld_phase = PH_ZERO;
            fld_digit = 1'b1;
          end else begin
            to_digits = 1'b1;
          end
        end
        PH_ZERO: begin
          // A leading zero may open a hex or octal prefix.
          if (c == "x" || c == "X") begin
            if (cur_mode != MODE_AUTO && cur_mode != MODE_HEX) begin
              fin = 1'b1;
              bad = 1'b1;
            end else begin
              fld_radix = RX_HEX;
              fld_digit = 1'b0;
              fld_phase = PH_DIGITS;
            end
          end else if ((c == "b" || c == "B") && cur_mode >= MODE_OCT) begin
            fin = 1'b1;
            bad = 1'b1;
          end else if (cur_mode == MODE_SDEC && c >= "0" && c <= "7") begin
            fin = 1'b1;
            bad = 1'b1;
          end else begin
            if (cur_mode == MODE_AUTO && c >= "0" && c <= "7") fld_radix = RX_OCT;
            to_digits = 1'b1;
          end
        end
        PH_DIGITS: begin
          to_digits = 1'b1;
        end
        default: begin
          // Skip leading space; the first other character picks the radix.
          if (!blank) begin
            if (c == 8'd0) begin
              fin = 1'b1;
            end else begin
              if (cur_mode == MODE_OCT) fld_radix = RX_OCT;
              else if (cur_mode == MODE_HEX) fld_radix = RX_HEX;
              else fld_radix = RX_DEC;
              if (cur_mode <= MODE_AUTO && (c == "-" || c == "+")) begin
                fld_neg   = (c == "-");
                fld_phase = PH_SIGN;
              end else if (c == "0") begin
                fld_phase = PH_ZERO;
                fld_digit = 1'b1;
              end else begin
                to_digits = 1'b1;
              end
            end
          end
        end
      endcase
    end

    // Digit accumulation with the overflow test against the size limit.
    if (to_digits) begin
      fld_phase = PH_DIGITS;
      if (c == 8'd0 || (fld_digit && blank)) begin
        fin = 1'b1;
      end else begin
        if (c >= "0" && c <= "9") dig = 64'(c - "0");
        else if (c >= "A" && c <= "F") dig = 64'(c - "A") + 64'd10;
        else if (c >= "a" && c <= "f") dig = 64'(c - "a") + 64'd10;
        else dig = 64'd99;
        if (fld_radix == RX_HEX) base = 64'd16;
        else if (fld_radix == RX_OCT) base = 64'd8;
        else base = 64'd10;
        if (dig >= base) begin
          fin = 1'b1;
          bad = 1'b1;
        end else begin
          if (fld_accum > (lim - dig) / base) fld_ovf = 1'b1;
          fld_accum = fld_accum * base + dig;
          fld_digit = 1'b1;
        end
      end
    end

    if (fin) begin
      if (!bad && !fld_ovf) v = (fld_neg ? 64'd0 - fld_accum : fld_accum) & mask;
      st = bad;
      clear_field();
    end
    return fin;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    errs++;
  endtask

  // Follow configuration writes, character beats and result beats.
  always @(posedge clk) begin : watch
    field_result_t want;
    logic [63:0]   v;
    logic          st;
    if (!rst_n) begin
      cur_mode = CONV_MODE_RST;
      cur_size = SIZE_SELECT_RST;
      clear_field();
      expected_fields.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_CONV_MODE) cur_mode = cfg_wdata;
        else cur_size = cfg_wdata;
      end
      if (in_valid && !in_stall) begin
        if (parse_step(in_char_in, v, st)) begin
          want.value  = v;
          want.status = st;
          expected_fields.push_back(want);
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_fields.size() == 0) begin
          report_mismatch("unexpected result beat", out_value, '0);
        end else begin
          want = expected_fields.pop_front();
          if (out_value !== want.value) report_mismatch("value", out_value, want.value);
          if (out_status !== want.status) begin
            report_mismatch("status", {63'd0, out_status}, {63'd0, want.status});
          end
          n_checked++;
          if (want.status) n_malformed++;
        end
      end
    end
    pending <= expected_fields.size();
  end

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the ASCII integer field parser.
// ----------------------------------------------------------------------------
// Feeds the parser a directed set of fields, then random fields under a
// series of register settings: well-formed numbers near the size limits with
// signs, prefixes and leading zeros, mixed with malformed sequences and raw
// bytes. Both channels idle at random. One phase holds the result side off
// for a long stretch. The checker module predicts and compares every result.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import aifp_pkg::*;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic [7:0]  in_char_in = 8'd0;
  logic        out_stall  = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = CFG_CONV_MODE;
  logic [2:0]  cfg_wdata  = 3'd0;
  logic        in_stall;
  logic        out_valid;
  logic [63:0] out_value;
  logic        out_status;

  int fail_count;
  int pending;
  int checked;
  int malformed;

  // Stimulus bookkeeping.
  logic [2:0] mode_now   = CONV_MODE_RST;
  logic [2:0] size_now   = SIZE_SELECT_RST;
  int         n_sent     = 0;
  int         n_settings = 1;
  bit         send_quiet = 1'b0;
  bit         recv_quiet = 1'b0;
  bit         long_hold  = 1'b0;

  logic [2:0] mode_list[5] = '{MODE_SDEC, MODE_AUTO, MODE_OCT, MODE_UDEC, MODE_HEX};

  ascii_integer_field_parser_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_char_in (in_char_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .out_status (out_status),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  aifp_field_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_char_in (in_char_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .out_status (out_status),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .malformed  (malformed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("Timeout: %0d results still expected", pending);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int draw_gap(input bit quiet);
    return quiet ? 0 : int'($urandom_range(0, 13));
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] space_char();
    case ($urandom_range(0, 2))
      0: return " ";
      1: return "\t";
      default: return "\n";
    endcase
  endfunction

  // Field terminator: mostly whitespace, some NUL, now and then a stray byte.
  function automatic logic [7:0] end_char();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return space_char();
    if (pick < 95) return 8'd0;
    return rand_byte();
  endfunction

  // Sends one character beat after a random gap and waits for acceptance.
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = draw_gap(send_quiet);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_char_in <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Sends v as digits of the given base, with hex letters in either case.
  task automatic send_number(input logic [63:0] v, input int base);
    logic [7:0]  digs[$];
    logic [63:0] b64;
    logic [63:0] d;
    bit          upper;
    b64   = 64'(base);
    upper = 1'($urandom_range(0, 1));
    do begin
      d = v % b64;
      if (d < 10) digs.push_front("0" + d[7:0]);
      else digs.push_front((upper ? "A" : "a") + d[7:0] - 8'd10);
      v = v / b64;
    end while (v != 0);
    foreach (digs[i]) send_char(digs[i]);
  endtask

  // One field for the current setting: mostly well formed, some broken.
  task automatic send_field();
    int          pick;
    int          base;
    bit          signed_mode;
    logic [63:0] mask;
    logic [63:0] lim;
    logic [63:0] mag;
    if (mode_now > MODE_HEX) begin
      repeat ($urandom_range(1, 4)) send_char(rand_byte());
      return;
    end
    if ($urandom_range(0, 99) < 12) begin
      case ($urandom_range(0, 4))
        0: send_char(rand_byte());
        1: send_text($urandom_range(0, 1) ? "0b" : "0B");
        2: begin
          send_char($urandom_range(0, 1) ? "-" : "+");
          send_char(space_char());
        end
        3: begin
          send_text("0x");
          send_char(end_char());
        end
        default: begin
          send_char("-");
          send_char(8'd0);
        end
      endcase
      return;
    end

    repeat ($urandom_range(0, 2)) send_char(space_char());
    signed_mode = (mode_now <= MODE_AUTO);
    if ((signed_mode && $urandom_range(0, 9) < 6) || $urandom_range(0, 19) == 0) begin
      send_char($urandom_range(0, 1) ? "-" : "+");
    end

    // Base and prefix follow the mode, with an odd misused prefix.
    base = 10;
    case (mode_now)
      MODE_OCT: begin
        base = 8;
        if ($urandom_range(0, 2) == 0) send_char("0");
      end
      MODE_HEX: begin
        base = 16;
        if ($urandom_range(0, 1)) send_text($urandom_range(0, 1) ? "0x" : "0X");
      end
      MODE_AUTO: begin
        pick = $urandom_range(0, 2);
        if (pick == 1) begin
          base = 8;
          send_char("0");
        end else if (pick == 2) begin
          base = 16;
          send_text($urandom_range(0, 1) ? "0x" : "0X");
        end
      end
      default: begin
        if ($urandom_range(0, 9) == 0) send_text("0x");
      end
    endcase
    if ($urandom_range(0, 9) == 0) send_char("0");

    case (size_now)
      SIZE_CHAR: mask = 64'hFF;
      SIZE_SHORT: mask = 64'hFFFF;
      SIZE_LONG, SIZE_LLONG: mask = {64{1'b1}};
      default: mask = 64'hFFFF_FFFF;
    endcase
    lim = signed_mode ? (mask >> 1) : mask;

    // Magnitudes cluster at the limit, just past it, and at small values.
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      send_number(lim, base);
    end else if (pick < 30) begin
      if (&lim) begin
        send_number(lim, base);
        send_char("0");
      end else begin
        send_number(lim + 64'd1, base);
      end
    end else if (pick < 45) begin
      send_number(64'($urandom_range(0, 20)), base);
    end else if (pick < 60) begin
      send_number({$urandom, $urandom}, base);
    end else begin
      mag = {$urandom, $urandom} >> $urandom_range(0, 63);
      send_number(mag & mask, base);
    end
    send_char(end_char());
  endtask

  // Drops valid, waits for all owed results, then lets the pipeline drain.
  task automatic wait_idle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [2:0] mode, input logic [2:0] size);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CONV_MODE;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_index <= CFG_SIZE_SELECT;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_we   <= 1'b0;
    mode_now = mode;
    size_now = size;
    n_settings++;
  endtask

  // Result side: a random stall before each beat, or one long hold-off.
  initial begin : result_sink
    int hold;
    wait (rst_n);
    forever begin
      if (long_hold) begin
        hold      = 200;
        long_hold = 1'b0;
      end else begin
        hold = draw_gap(recv_quiet);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int budget_end;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed fields under the reset setting (auto base, int).
    send_text("\t+0x1f\n");
    send_text("-017 ");
    send_text("0");
    send_char(8'd0);
    send_text("0 ");
    send_char(8'd0);
    send_text("-");
    send_char(8'd0);
    send_text("+ ");
    send_text("0x");
    send_char(8'd0);
    send_char(8'hFF);
    send_text("2147483648 ");
    wait_idle();

    // Every mode at the smallest and largest size, then random settings.
    for (int ph = 0; ph < 18; ph++) begin
      if (ph < 10) begin
        set_config(mode_list[ph % 5], (ph < 5) ? SIZE_CHAR : SIZE_LLONG);
      end else if (ph == 12) begin
        set_config(3'(MODE_HEX + 1 + $urandom_range(0, 2)), 3'($urandom));
      end else begin
        set_config(mode_list[$urandom_range(0, 4)], 3'($urandom));
      end
      long_hold  = (ph == 2);
      budget_end = n_sent + 110;
      while (n_sent < budget_end) begin
        if ($urandom_range(0, 7) == 0) send_quiet = !send_quiet;
        if ($urandom_range(0, 7) == 0) recv_quiet = !recv_quiet;
        send_field();
      end
      // A NUL closes whatever field is open before the next setting.
      send_char(8'd0);
      wait_idle();
    end

    $display("Sent %0d characters under %0d register settings.", n_sent, n_settings);
    $display("Checked %0d results, %0d of them flagged malformed.", checked, malformed);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
